[rtl/evpd_pkg.sv]
`timescale 1ns / 1ps

package evpd_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int APB_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_USE_DEFAULT_PREFIX = 3'd0,
		REG_DEFAULT_KEY_PREFIX = 3'd1,
		REG_PREFIX_SHIFT       = 3'd2,
		REG_CHECK_ENABLE       = 3'd3,
		REG_KEY_MATCH          = 3'd4,
		REG_KEY_MASK           = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        use_default_prefix;
		logic [31:0] default_key_prefix;
		logic [4:0]  prefix_shift;
		logic        check_enable;
		logic [31:0] key_match;
		logic [31:0] key_mask;
	} cfg_t;

	// one completed event, prefixes already applied
	typedef struct packed {
		logic [31:0] key;
		logic        with_pay;
		logic [31:0] pay;
		logic        spikeable;
	} event_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

[rtl/evpd_front.sv]
`timescale 1ns / 1ps

module evpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  evpd_pkg::cfg_t        cfg,
	input  logic                  accept,
	input  logic [15:0]           halfword,
	input  logic                  start_req,
	output logic                  push,
	output evpd_pkg::event_t      ev
);
	import evpd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_KEY_PREFIX,
		PH_PAY_PREFIX,
		PH_EVENTS
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  events_left_q;
	logic        upper_q;
	logic        wide_q;
	logic        pay_present_q;
	logic        pp_mode_q;
	logic [31:0] key_prefix_q;
	logic [31:0] pay_prefix_q;
	logic [31:0] part_key_q;
	logic [15:0] part_pay_lo_q;
	logic [1:0]  word_q;

	logic [31:0] hw_lo;
	logic [31:0] hw_hi;
	phase_t      after_pp;

	assign hw_lo = {16'h0000, halfword};
	assign hw_hi = {halfword, 16'h0000};
	assign after_pp = (events_left_q != 8'd0) ? PH_EVENTS : PH_IDLE;

	// event completion and its record
	always_comb begin
		push = 1'b0;
		ev.key = 32'h0;
		ev.with_pay = 1'b0;
		ev.pay = 32'h0;
		ev.spikeable = 1'b0;
		if (accept && !start_req && phase_q == PH_EVENTS) begin
			unique case ({wide_q, pay_present_q})
				2'b00: begin
					push = 1'b1;
					ev.key = (upper_q ? hw_lo : hw_hi) | key_prefix_q;
					ev.with_pay = pp_mode_q;
					ev.pay = pay_prefix_q;
					ev.spikeable = !pp_mode_q;
				end
				2'b01: begin
					push = (word_q != 2'd0);
					ev.key = (upper_q ? {16'h0000, part_key_q[15:0]}
						: {part_key_q[15:0], 16'h0000}) | key_prefix_q;
					ev.with_pay = 1'b1;
					ev.pay = hw_lo | pay_prefix_q;
					ev.spikeable = 1'b1;
				end
				2'b10: begin
					push = (word_q != 2'd0);
					ev.key = {halfword, part_key_q[15:0]} | key_prefix_q;
					ev.with_pay = pp_mode_q;
					ev.pay = pay_prefix_q;
					ev.spikeable = !pp_mode_q;
				end
				2'b11: begin
					push = (word_q == 2'd3);
					ev.key = part_key_q | key_prefix_q;
					ev.with_pay = 1'b1;
					ev.pay = {halfword, part_pay_lo_q} | pay_prefix_q;
					ev.spikeable = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			events_left_q <= 8'd0;
			upper_q <= 1'b0;
			wide_q <= 1'b0;
			pay_present_q <= 1'b0;
			pp_mode_q <= 1'b0;
			key_prefix_q <= 32'h0;
			pay_prefix_q <= 32'h0;
			part_key_q <= 32'h0;
			part_pay_lo_q <= 16'h0;
			word_q <= 2'd0;
		end else if (accept) begin
			if (start_req) begin
				pp_mode_q <= halfword[13];
				pay_present_q <= halfword[10];
				wide_q <= halfword[11];
				events_left_q <= halfword[7:0];
				key_prefix_q <= cfg.default_key_prefix;
				pay_prefix_q <= 32'h0;
				part_key_q <= 32'h0;
				part_pay_lo_q <= 16'h0;
				word_q <= 2'd0;
				if (!halfword[15] && cfg.use_default_prefix) begin
					upper_q <= (cfg.prefix_shift == 5'd0);
				end else begin
					upper_q <= halfword[14];
				end
				priority if (halfword[15]) begin
					phase_q <= PH_KEY_PREFIX;
				end else if (halfword[13]) begin
					phase_q <= PH_PAY_PREFIX;
				end else begin
					phase_q <= (halfword[7:0] != 8'd0) ? PH_EVENTS : PH_IDLE;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_KEY_PREFIX: begin
						key_prefix_q <= upper_q ? hw_hi : hw_lo;
						word_q <= 2'd0;
						phase_q <= pp_mode_q ? PH_PAY_PREFIX : after_pp;
					end
					PH_PAY_PREFIX: begin
						priority if (!wide_q) begin
							pay_prefix_q <= hw_lo;
							word_q <= 2'd0;
							phase_q <= after_pp;
						end else if (word_q == 2'd0) begin
							pay_prefix_q <= hw_lo;
							word_q <= 2'd1;
						end else begin
							pay_prefix_q <= pay_prefix_q | hw_hi;
							word_q <= 2'd0;
							phase_q <= after_pp;
						end
					end
					PH_EVENTS: begin
						if (push) begin
							word_q <= 2'd0;
							events_left_q <= events_left_q - 8'd1;
							if (events_left_q == 8'd1) begin
								phase_q <= PH_IDLE;
							end
						end else begin
							unique case (word_q)
								2'd0: part_key_q <= hw_lo;
								2'd1: part_key_q <= part_key_q | hw_hi;
								2'd2: part_pay_lo_q <= halfword;
								default: begin
								end
							endcase
							word_q <= word_q + 2'd1;
						end
					end
				endcase
			end
		end
	end

endmodule

[rtl/evpd_queue.sv]
`timescale 1ns / 1ps

module evpd_queue #(
	parameter int DEPTH = evpd_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  evpd_pkg::event_t        wr_data,
	input  logic                    pop,
	output evpd_pkg::event_t        rd_data,
	output evpd_pkg::queue_status_t status
);
	import evpd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	event_t        mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_data = mem[rd_ptr_q];
	assign status.full = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/evpd_back.sv]
`timescale 1ns / 1ps

module evpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  evpd_pkg::cfg_t     cfg,
	input  logic               ev_valid,
	input  evpd_pkg::event_t   ev,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               status,
	output logic [31:0]        mc_key,
	output logic [31:0]        mc_payload,
	output logic               has_payload,
	output logic               spike_valid,
	output logic [31:0]        spike_index,
	output logic [31:0]        discard_total
);
	import evpd_pkg::*;

	logic        out_valid_q;
	logic [31:0] discard_q;
	logic        ok;
	logic        spike;

	assign ok = !cfg.check_enable || ((ev.key & cfg.key_mask) == cfg.key_match);
	assign spike = ok && ev.spikeable && cfg.check_enable;
	assign pop = ev_valid && (!out_valid_q || rsp_ready);

	assign rsp_valid = out_valid_q;
	assign discard_total = discard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			discard_q <= 32'h0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (!ok) begin
					discard_q <= discard_q + 32'd1;
				end
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status <= !ok;
			mc_key <= ev.key;
			mc_payload <= (ok && ev.with_pay) ? ev.pay : 32'h0;
			has_payload <= ok && ev.with_pay;
			spike_valid <= spike;
			spike_index <= spike ? (ev.key & ~cfg.key_mask) : 32'h0;
		end
	end

	// discard count moves only with a discarded event
	a_discard_inc: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !ok |=> discard_q == $past(discard_q) + 32'd1)
		else $error("discard count did not advance");

	a_discard_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !ok) |=> discard_q == $past(discard_q))
		else $error("discard count moved without a discard");

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status |-> !has_payload && !spike_valid && spike_index == 32'h0)
		else $error("discarded event carries payload or spike");

	a_spike_needs_check: assert property (@(posedge clk) disable iff (!arst_n)
		pop && spike |-> cfg.check_enable && ok)
		else $error("spike recorded without a passing check");

endmodule

[rtl/event_packet_to_multicast_decoder_top.sv]
`timescale 1ns / 1ps
// rsp_valid rises once the event ended by a halfword has passed through the queue and the output register
// throughput: one halfword per cycle; the parser takes a word whenever the event queue has room
// the queue (QUEUE_DEPTH entries) and the output register let the parser run while results stall
// configuration writes are registered in the access phase; prdata returns the addressed register
// reset (arst_n low, asynchronous) clears the registers, parser state, queue and discard count

module event_packet_to_multicast_decoder_top #(
	parameter int QUEUE_DEPTH = evpd_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [evpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [15:0]                   halfword,
	input  logic                          start_req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          status,
	output logic [31:0]                   mc_key,
	output logic [31:0]                   mc_payload,
	output logic                          has_payload,
	output logic                          spike_valid,
	output logic [31:0]                   spike_index,
	output logic [31:0]                   discard_total
);
	import evpd_pkg::*;

	cfg_t          cfg_q;
	logic          wr_en;
	logic [2:0]    reg_sel;
	logic          accept;
	logic          push;
	logic          pop;
	event_t        ev_in;
	event_t        ev_out;
	queue_status_t q_status;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_USE_DEFAULT_PREFIX: cfg_q.use_default_prefix <= pwdata[0];
				REG_DEFAULT_KEY_PREFIX: cfg_q.default_key_prefix <= pwdata;
				REG_PREFIX_SHIFT:       cfg_q.prefix_shift <= pwdata[4:0];
				REG_CHECK_ENABLE:       cfg_q.check_enable <= pwdata[0];
				REG_KEY_MATCH:          cfg_q.key_match <= pwdata;
				REG_KEY_MASK:           cfg_q.key_mask <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_USE_DEFAULT_PREFIX: prdata = {31'h0, cfg_q.use_default_prefix};
			REG_DEFAULT_KEY_PREFIX: prdata = cfg_q.default_key_prefix;
			REG_PREFIX_SHIFT:       prdata = {27'h0, cfg_q.prefix_shift};
			REG_CHECK_ENABLE:       prdata = {31'h0, cfg_q.check_enable};
			REG_KEY_MATCH:          prdata = cfg_q.key_match;
			REG_KEY_MASK:           prdata = cfg_q.key_mask;
			default:                prdata = 32'h0;
		endcase
	end

	assign req_ready = !q_status.full;
	assign accept = req_valid && req_ready;

	evpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.halfword  (halfword),
		.start_req (start_req),
		.push      (push),
		.ev        (ev_in)
	);

	evpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (ev_in),
		.pop     (pop),
		.rd_data (ev_out),
		.status  (q_status)
	);

	evpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.ev_valid      (q_status.not_empty),
		.ev            (ev_out),
		.pop           (pop),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.mc_key        (mc_key),
		.mc_payload    (mc_payload),
		.has_payload   (has_payload),
		.spike_valid   (spike_valid),
		.spike_index   (spike_index),
		.discard_total (discard_total)
	);

endmodule

[tb/event_packet_to_multicast_decoder_top_tb.sv]
`timescale 1ns / 1ps

module event_packet_to_multicast_decoder_top_tb;
	import evpd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	typedef enum logic [1:0] {
		PARSE_IDLE,
		PARSE_KEY_PREFIX,
		PARSE_PAY_PREFIX,
		PARSE_EVENTS
	} parse_phase_t;

	typedef struct {
		logic        status;
		logic [31:0] key;
		logic [31:0] payload;
		logic        has_payload;
		logic        spike;
		logic [31:0] spike_index;
		logic [31:0] discards;
	} mc_packet_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  req_valid;
	logic                  req_ready;
	logic [15:0]           halfword;
	logic                  start_req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	logic                  status;
	logic [31:0]           mc_key;
	logic [31:0]           mc_payload;
	logic                  has_payload;
	logic                  spike_valid;
	logic [31:0]           spike_index;
	logic [31:0]           discard_total;

	event_packet_to_multicast_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.halfword(halfword),
		.start_req(start_req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.mc_key(mc_key),
		.mc_payload(mc_payload),
		.has_payload(has_payload),
		.spike_valid(spike_valid),
		.spike_index(spike_index),
		.discard_total(discard_total)
	);

	// shadow of the configuration registers
	logic        cfg_use_default = 1'b0;
	logic [31:0] cfg_default_prefix = '0;
	logic [4:0]  cfg_prefix_shift = '0;
	logic        cfg_check = 1'b0;
	logic [31:0] cfg_key_match = '0;
	logic [31:0] cfg_key_mask = '0;

	// decoder state as predicted
	parse_phase_t phase = PARSE_IDLE;
	logic [7:0]   evts_left = '0;
	logic         upper_fmt = 1'b0;
	logic         wide = 1'b0;
	logic         pay_on = 1'b0;
	logic         pay_pfx_on = 1'b0;
	logic [31:0]  key_pfx = '0;
	logic [31:0]  pay_pfx = '0;
	logic [31:0]  part_key = '0;
	logic [15:0]  part_pay_lo = '0;
	logic [1:0]   word_idx = '0;
	logic [31:0]  discard_tally = '0;

	mc_packet_t expected_packets[$];
	int         fail_count = 0;
	int         items_sent = 0;
	int         quiet_cycles = 0;
	bit         gaps_on = 1'b1;
	bit         stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void emit_packet(input logic [31:0] k, input logic with_pay,
			input logic [31:0] pay, input logic spikeable);
		mc_packet_t pk;
		logic       ok;
		logic       spk;
		ok = !cfg_check || ((k & cfg_key_mask) == cfg_key_match);
		spk = ok && spikeable && cfg_check;
		if (!ok)
			discard_tally = discard_tally + 32'd1;
		pk.status = !ok;
		pk.key = k;
		pk.payload = (ok && with_pay) ? pay : 32'h0;
		pk.has_payload = ok && with_pay;
		pk.spike = spk;
		pk.spike_index = spk ? (k & ~cfg_key_mask) : 32'h0;
		pk.discards = discard_tally;
		expected_packets.push_back(pk);
		word_idx = '0;
		evts_left = evts_left - 8'd1;
		if (evts_left == 8'd0)
			phase = PARSE_IDLE;
	endfunction

	function automatic void finish_pay_prefix();
		word_idx = '0;
		phase = (evts_left != 8'd0) ? PARSE_EVENTS : PARSE_IDLE;
	endfunction

	function automatic void finish_key_prefix();
		word_idx = '0;
		if (pay_pfx_on)
			phase = PARSE_PAY_PREFIX;
		else
			finish_pay_prefix();
	endfunction

	function automatic void decode_halfword(input logic [15:0] hw, input logic st);
		if (st) begin
			upper_fmt = hw[14];
			pay_pfx_on = hw[13];
			pay_on = hw[10];
			wide = hw[11];
			evts_left = hw[7:0];
			key_pfx = cfg_default_prefix;
			pay_pfx = '0;
			part_key = '0;
			part_pay_lo = '0;
			word_idx = '0;
			if (!hw[15] && cfg_use_default)
				upper_fmt = (cfg_prefix_shift == 5'd0);
			if (hw[15])
				phase = PARSE_KEY_PREFIX;
			else
				finish_key_prefix();
		end else begin
			case (phase)
				PARSE_KEY_PREFIX: begin
					key_pfx = upper_fmt ? {hw, 16'h0} : {16'h0, hw};
					finish_key_prefix();
				end
				PARSE_PAY_PREFIX: begin
					if (!wide) begin
						pay_pfx = {16'h0, hw};
						finish_pay_prefix();
					end else if (word_idx == 2'd0) begin
						pay_pfx = {16'h0, hw};
						word_idx = 2'd1;
					end else begin
						pay_pfx = pay_pfx | {hw, 16'h0};
						finish_pay_prefix();
					end
				end
				PARSE_EVENTS: begin
					if (!wide) begin
						if (!pay_on)
							emit_packet((upper_fmt ? {16'h0, hw} : {hw, 16'h0}) | key_pfx,
								pay_pfx_on, pay_pfx, !pay_pfx_on);
						else if (word_idx == 2'd0) begin
							part_key = {16'h0, hw};
							word_idx = 2'd1;
						end else
							emit_packet((upper_fmt ? part_key : (part_key << 16)) | key_pfx,
								1'b1, {16'h0, hw} | pay_pfx, 1'b1);
					end else if (!pay_on) begin
						if (word_idx == 2'd0) begin
							part_key = {16'h0, hw};
							word_idx = 2'd1;
						end else
							emit_packet({hw, 16'h0} | part_key | key_pfx, pay_pfx_on, pay_pfx,
								!pay_pfx_on);
					end else begin
						case (word_idx)
							2'd0: begin
								part_key = {16'h0, hw};
								word_idx = 2'd1;
							end
							2'd1: begin
								part_key = part_key | {hw, 16'h0};
								word_idx = 2'd2;
							end
							2'd2: begin
								part_pay_lo = hw;
								word_idx = 2'd3;
							end
							default: emit_packet(part_key | key_pfx, 1'b1,
								{hw, part_pay_lo} | pay_pfx, 1'b1);
						endcase
					end
				end
				default: ;
			endcase
		end
	endfunction

	// one halfword transfer; called and returns at a falling edge
	task automatic send_halfword(input logic [15:0] hw, input logic st);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_valid <= 1'b1;
		halfword <= hw;
		start_req <= st;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		decode_halfword(hw, st);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_packets.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write a register, then read it back
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] want;
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_USE_DEFAULT_PREFIX: begin
				cfg_use_default = val[0];
				want = {31'h0, val[0]};
			end
			REG_DEFAULT_KEY_PREFIX: begin
				cfg_default_prefix = val;
				want = val;
			end
			REG_PREFIX_SHIFT: begin
				cfg_prefix_shift = val[4:0];
				want = {27'h0, val[4:0]};
			end
			REG_CHECK_ENABLE: begin
				cfg_check = val[0];
				want = {31'h0, val[0]};
			end
			REG_KEY_MATCH: begin
				cfg_key_match = val;
				want = val;
			end
			REG_KEY_MASK: begin
				cfg_key_mask = val;
				want = val;
			end
			default: want = '0;
		endcase
		check_field(idx.name(), want, got);
	endtask

	task automatic configure(input logic use_def, input logic [31:0] def_pfx,
			input logic [4:0] shift, input logic chk, input logic [31:0] space,
			input logic [31:0] mask);
		drain_results();
		write_reg(REG_USE_DEFAULT_PREFIX, {31'h0, use_def});
		write_reg(REG_DEFAULT_KEY_PREFIX, def_pfx);
		write_reg(REG_PREFIX_SHIFT, {27'h0, shift});
		write_reg(REG_CHECK_ENABLE, {31'h0, chk});
		write_reg(REG_KEY_MATCH, space);
		write_reg(REG_KEY_MASK, mask);
	endtask

	// key whose checked bits match the expected value when aiming
	function automatic logic [31:0] pick_key(input bit aim);
		return aim ? ((cfg_key_match & cfg_key_mask) | ($urandom & ~cfg_key_mask)) : $urandom;
	endfunction

	task automatic send_random_message(input bit aim);
		logic [15:0] hdr;
		logic [15:0] words[$];
		logic [31:0] k;
		logic [31:0] p;
		logic        upper;
		int          n;
		int          cut;
		hdr = 16'($urandom);
		case ($urandom_range(0, 9))
			0: hdr[7:0] = 8'h00;
			1: hdr[7:0] = 8'hFF;
			default: hdr[7:0] = 8'($urandom_range(1, 6));
		endcase
		n = int'(hdr[7:0]);
		upper = hdr[14];
		if (!hdr[15] && cfg_use_default)
			upper = (cfg_prefix_shift == 5'd0);
		words.push_back(hdr);
		if (hdr[15]) begin
			k = pick_key(aim);
			words.push_back(upper ? k[31:16] : k[15:0]);
		end
		if (hdr[13]) begin
			words.push_back(16'($urandom));
			if (hdr[11])
				words.push_back(16'($urandom));
		end
		for (int i = 0; i < n && words.size() < 40; i++) begin
			k = pick_key(aim);
			if (hdr[11]) begin
				words.push_back(k[15:0]);
				words.push_back(k[31:16]);
			end else
				words.push_back(upper ? k[15:0] : k[31:16]);
			if (hdr[10]) begin
				p = $urandom;
				words.push_back(p[15:0]);
				if (hdr[11])
					words.push_back(p[31:16]);
			end
		end
		// broken message, cut short by the next header
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, words.size());
			while (words.size() > cut) words.delete(words.size() - 1);
		end
		foreach (words[i]) send_halfword(words[i], i == 0);
		repeat ($urandom_range(0, 2)) send_halfword(16'($urandom), 1'b0);
	endtask

	task automatic run_messages(input int budget);
		int first;
		first = items_sent;
		while (items_sent - first < budget) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 8))
					send_halfword(16'($urandom), $urandom_range(0, 5) == 0);
			else
				send_random_message($urandom_range(0, 1) == 1);
		end
	endtask

	task automatic test_directed_formats();
		logic [16:0] script [24];
		script = '{
			17'h1_C001, 17'h0_FFFF, 17'h0_0000,
			17'h1_0C01, 17'h0_FFFF, 17'h0_FFFF, 17'h0_0000, 17'h0_FFFF,
			17'h1_2801, 17'h0_1234, 17'h0_FFFF, 17'h0_0001, 17'h0_8000,
			17'h1_A000, 17'h0_00FF, 17'h0_FFFF, 17'h0_FFFF,
			17'h1_04FF, 17'h0_AAAA, 17'h0_5555, 17'h0_1234,
			17'h1_1401, 17'h0_FFFF, 17'h0_0000
		};
		foreach (script[i]) send_halfword(script[i][15:0], script[i][16]);
	endtask

	task automatic test_default_prefix_upper();
		configure(1'b1, 32'hFFFF_FFFF, 5'd0, 1'b0, 32'h0, 32'h0);
		run_messages(150);
	endtask

	task automatic test_check_lower_format();
		configure(1'b1, 32'h0000_1234, 5'd31, 1'b1, 32'hABCD_0000, 32'hFFFF_0000);
		run_messages(170);
	endtask

	task automatic test_full_mask();
		configure(1'b0, 32'h0, 5'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_messages(150);
	endtask

	task automatic test_zero_mask();
		configure(1'b1, 32'h8000_0001, 5'd1, 1'b1, 32'h0, 32'h0);
		run_messages(150);
	endtask

	task automatic test_random_settings();
		logic [31:0] mask;
		logic [31:0] space;
		logic [4:0]  shift;
		repeat (3) begin
			mask = $urandom;
			space = $urandom & mask;
			case ($urandom_range(0, 2))
				0: shift = 5'd0;
				1: shift = 5'd31;
				default: shift = 5'($urandom);
			endcase
			configure($urandom_range(0, 1) == 1, ($urandom_range(0, 1) == 1) ? space : $urandom,
				shift, $urandom_range(0, 1) == 1, space, mask);
			run_messages(80);
		end
	endtask

	task automatic test_final_no_idle();
		logic [31:0] mask;
		mask = $urandom;
		configure(1'b1, 32'h0, 5'($urandom), 1'b1, $urandom & mask, mask);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_messages(170);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		halfword = '0;
		start_req = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed_formats();
		test_default_prefix_upper();
		test_check_lower_format();
		test_full_mask();
		test_zero_mask();
		test_random_settings();
		test_final_no_idle();
		drain_results();
		if (fail_count == 0)
			$display("event_packet_to_multicast_decoder_top_tb: done, clean");
		else
			$display("event_packet_to_multicast_decoder_top_tb: done, errors");
		$finish;
	end

	// result side backpressure in bursts
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else
				rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		mc_packet_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_packets.size() == 0) begin
				$error("packet transfer with nothing expected, key 0x%08h", mc_key);
				fail_count++;
			end else begin
				want = expected_packets.pop_front();
				check_field("status", {31'h0, want.status}, {31'h0, status});
				check_field("mc_key", want.key, mc_key);
				check_field("mc_payload", want.payload, mc_payload);
				check_field("has_payload", {31'h0, want.has_payload}, {31'h0, has_payload});
				check_field("spike_valid", {31'h0, want.spike}, {31'h0, spike_valid});
				check_field("spike_index", want.spike_index, spike_index);
				check_field("discard_total", want.discards, discard_total);
			end
		end
	end

	// ends a hung run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("event_packet_to_multicast_decoder_top_tb: done, errors");
			$finish;
		end
	end

endmodule
